// ----- rtl/c6502_eu_pkg.sv -----
package c6502_eu_pkg;

   // Operation codes, dense and in alphabetical order of mnemonic
   localparam logic [5:0] FN_ADC = 6'd0;
   localparam logic [5:0] FN_AND = 6'd1;
   localparam logic [5:0] FN_ASL = 6'd2;
   localparam logic [5:0] FN_BCC = 6'd3;
   localparam logic [5:0] FN_BCS = 6'd4;
   localparam logic [5:0] FN_BEQ = 6'd5;
   localparam logic [5:0] FN_BIT = 6'd6;
   localparam logic [5:0] FN_BMI = 6'd7;
   localparam logic [5:0] FN_BNE = 6'd8;
   localparam logic [5:0] FN_BPL = 6'd9;
   localparam logic [5:0] FN_BVC = 6'd10;
   localparam logic [5:0] FN_BVS = 6'd11;
   localparam logic [5:0] FN_CLC = 6'd12;
   localparam logic [5:0] FN_CLD = 6'd13;
   localparam logic [5:0] FN_CLI = 6'd14;
   localparam logic [5:0] FN_CLV = 6'd15;
   localparam logic [5:0] FN_CMP = 6'd16;
   localparam logic [5:0] FN_CPX = 6'd17;
   localparam logic [5:0] FN_CPY = 6'd18;
   localparam logic [5:0] FN_DEC = 6'd19;
   localparam logic [5:0] FN_DEX = 6'd20;
   localparam logic [5:0] FN_DEY = 6'd21;
   localparam logic [5:0] FN_EOR = 6'd22;
   localparam logic [5:0] FN_INC = 6'd23;
   localparam logic [5:0] FN_INX = 6'd24;
   localparam logic [5:0] FN_INY = 6'd25;
   localparam logic [5:0] FN_LDA = 6'd26;
   localparam logic [5:0] FN_LDX = 6'd27;
   localparam logic [5:0] FN_LDY = 6'd28;
   localparam logic [5:0] FN_LSR = 6'd29;
   localparam logic [5:0] FN_NOP = 6'd30;
   localparam logic [5:0] FN_ORA = 6'd31;
   localparam logic [5:0] FN_ROL = 6'd32;
   localparam logic [5:0] FN_ROR = 6'd33;
   localparam logic [5:0] FN_SBC = 6'd34;
   localparam logic [5:0] FN_SEC = 6'd35;
   localparam logic [5:0] FN_SED = 6'd36;
   localparam logic [5:0] FN_SEI = 6'd37;
   localparam logic [5:0] FN_STA = 6'd38;
   localparam logic [5:0] FN_STX = 6'd39;
   localparam logic [5:0] FN_STY = 6'd40;
   localparam logic [5:0] FN_TAX = 6'd41;
   localparam logic [5:0] FN_TAY = 6'd42;
   localparam logic [5:0] FN_TSX = 6'd43;
   localparam logic [5:0] FN_TXA = 6'd44;
   localparam logic [5:0] FN_TXS = 6'd45;
   localparam logic [5:0] FN_TYA = 6'd46;

   // Bit positions in the status byte N V 1 B D I Z C
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_D = 3;
   localparam int FLAG_I = 2;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   // Values after reset
   localparam logic [7:0] SP_RESET     = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;

   // Programmer-visible registers
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] status;
   } regs_type;

   // One input item
   typedef struct packed {
      logic [5:0]  func;
      logic [7:0]  operand;
      logic        to_accumulator;
      logic [15:0] current_pc;
   } item_type;

   // One result item
   typedef struct packed {
      logic [7:0]  acc_value;
      logic [7:0]  x_value;
      logic [7:0]  y_value;
      logic [7:0]  sp_value;
      logic [7:0]  status_value;
      logic        store_enable;
      logic [7:0]  store_data;
      logic        branch_taken;
      logic [15:0] next_pc;
      logic        unsupported;
   } result_type;

endpackage

// ----- rtl/c6502_eu_if.sv -----
// Request channel: one operation per item
interface c6502_eu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  func;
   logic [7:0]  operand;
   logic        to_accumulator;
   logic [15:0] current_pc;

   modport source (output valid, output func, output operand, output to_accumulator,
                   output current_pc, input ready);
   modport sink (input valid, input func, input operand, input to_accumulator,
                 input current_pc, output ready);
endinterface

// Response channel: register file, store request and branch outcome per item
interface c6502_eu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  acc_value;
   logic [7:0]  x_value;
   logic [7:0]  y_value;
   logic [7:0]  sp_value;
   logic [7:0]  status_value;
   logic        store_enable;
   logic [7:0]  store_data;
   logic        branch_taken;
   logic [15:0] next_pc;
   logic        unsupported;

   modport source (output valid, output acc_value, output x_value, output y_value,
                   output sp_value, output status_value, output store_enable,
                   output store_data, output branch_taken, output next_pc,
                   output unsupported, input ready);
   modport sink (input valid, input acc_value, input x_value, input y_value,
                 input sp_value, input status_value, input store_enable,
                 input store_data, input branch_taken, input next_pc,
                 input unsupported, output ready);
endinterface

// ----- rtl/c6502_eu_alu.sv -----
module c6502_eu_alu (
   input  c6502_eu_pkg::item_type   item,
   input  c6502_eu_pkg::regs_type   cur,
   output c6502_eu_pkg::regs_type   nxt,
   output c6502_eu_pkg::result_type res
);

   logic [7:0]  m;
   logic [7:0]  m_eff;
   logic [8:0]  sum;
   logic        ovf;
   logic [7:0]  cmp_reg;
   logic [8:0]  diff;
   logic [7:0]  src;
   logic        cin;
   logic [7:0]  shift_r;
   logic        shift_c;
   logic        shift_op;
   logic        is_branch;
   logic        cond;
   logic [15:0] target;

   // Update Z and N from a result byte, leaving the other flags untouched.
   function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q = p;
      q[c6502_eu_pkg::FLAG_Z] = (v == 8'd0);
      q[c6502_eu_pkg::FLAG_N] = v[7];
      return q;
   endfunction

   // Shared adder: SBC adds the inverted operand, so borrow is the inverted carry.
   assign m     = item.operand;
   assign cin   = cur.status[c6502_eu_pkg::FLAG_C];
   assign m_eff = (item.func == c6502_eu_pkg::FN_SBC) ? ~m : m;
   assign sum   = {1'b0, cur.acc} + {1'b0, m_eff} + {8'd0, cin};
   assign ovf   = ~(cur.acc[7] ^ m_eff[7]) & (cur.acc[7] ^ sum[7]);

   // Shared comparator: carry set when the register is at least the operand.
   always_comb begin
      case (item.func)
         c6502_eu_pkg::FN_CPX: cmp_reg = cur.x;
         c6502_eu_pkg::FN_CPY: cmp_reg = cur.y;
         default:              cmp_reg = cur.acc;
      endcase
   end
   assign diff = {1'b0, cmp_reg} - {1'b0, m};

   // Shift source and branch target
   assign src    = item.to_accumulator ? cur.acc : m;
   assign target = item.current_pc + {{8{m[7]}}, m};

   // Operation decode
   always_comb begin
      nxt       = cur;
      shift_r   = 8'd0;
      shift_c   = 1'b0;
      shift_op  = 1'b0;
      is_branch = 1'b0;
      cond      = 1'b0;
      res              = '0;
      res.next_pc      = item.current_pc;
      case (item.func)
         c6502_eu_pkg::FN_ADC, c6502_eu_pkg::FN_SBC: begin
            nxt.acc = sum[7:0];
            nxt.status[c6502_eu_pkg::FLAG_C] = sum[8];
            nxt.status[c6502_eu_pkg::FLAG_V] = ovf;
            nxt.status = with_nz(nxt.status, sum[7:0]);
         end
         c6502_eu_pkg::FN_AND: begin
            nxt.acc = cur.acc & m;
            nxt.status = with_nz(cur.status, cur.acc & m);
         end
         c6502_eu_pkg::FN_EOR: begin
            nxt.acc = cur.acc ^ m;
            nxt.status = with_nz(cur.status, cur.acc ^ m);
         end
         c6502_eu_pkg::FN_ORA: begin
            nxt.acc = cur.acc | m;
            nxt.status = with_nz(cur.status, cur.acc | m);
         end
         c6502_eu_pkg::FN_ASL: begin
            shift_op = 1'b1;
            shift_r  = {src[6:0], 1'b0};
            shift_c  = src[7];
         end
         c6502_eu_pkg::FN_LSR: begin
            shift_op = 1'b1;
            shift_r  = {1'b0, src[7:1]};
            shift_c  = src[0];
         end
         c6502_eu_pkg::FN_ROL: begin
            shift_op = 1'b1;
            shift_r  = {src[6:0], cin};
            shift_c  = src[7];
         end
         c6502_eu_pkg::FN_ROR: begin
            shift_op = 1'b1;
            shift_r  = {cin, src[7:1]};
            shift_c  = src[0];
         end
         c6502_eu_pkg::FN_BCC: begin
            is_branch = 1'b1;
            cond = ~cur.status[c6502_eu_pkg::FLAG_C];
         end
         c6502_eu_pkg::FN_BCS: begin
            is_branch = 1'b1;
            cond = cur.status[c6502_eu_pkg::FLAG_C];
         end
         c6502_eu_pkg::FN_BEQ: begin
            is_branch = 1'b1;
            cond = cur.status[c6502_eu_pkg::FLAG_Z];
         end
         c6502_eu_pkg::FN_BNE: begin
            is_branch = 1'b1;
            cond = ~cur.status[c6502_eu_pkg::FLAG_Z];
         end
         c6502_eu_pkg::FN_BMI: begin
            is_branch = 1'b1;
            cond = cur.status[c6502_eu_pkg::FLAG_N];
         end
         c6502_eu_pkg::FN_BPL: begin
            is_branch = 1'b1;
            cond = ~cur.status[c6502_eu_pkg::FLAG_N];
         end
         c6502_eu_pkg::FN_BVC: begin
            is_branch = 1'b1;
            cond = ~cur.status[c6502_eu_pkg::FLAG_V];
         end
         c6502_eu_pkg::FN_BVS: begin
            is_branch = 1'b1;
            cond = cur.status[c6502_eu_pkg::FLAG_V];
         end
         c6502_eu_pkg::FN_BIT: begin
            nxt.status[c6502_eu_pkg::FLAG_Z] = ((m & cur.acc) == 8'd0);
            nxt.status[c6502_eu_pkg::FLAG_V] = m[6];
            nxt.status[c6502_eu_pkg::FLAG_N] = m[7];
         end
         c6502_eu_pkg::FN_CLC: nxt.status[c6502_eu_pkg::FLAG_C] = 1'b0;
         c6502_eu_pkg::FN_CLD: nxt.status[c6502_eu_pkg::FLAG_D] = 1'b0;
         c6502_eu_pkg::FN_CLI: nxt.status[c6502_eu_pkg::FLAG_I] = 1'b0;
         c6502_eu_pkg::FN_CLV: nxt.status[c6502_eu_pkg::FLAG_V] = 1'b0;
         c6502_eu_pkg::FN_SEC: nxt.status[c6502_eu_pkg::FLAG_C] = 1'b1;
         c6502_eu_pkg::FN_SED: nxt.status[c6502_eu_pkg::FLAG_D] = 1'b1;
         c6502_eu_pkg::FN_SEI: nxt.status[c6502_eu_pkg::FLAG_I] = 1'b1;
         c6502_eu_pkg::FN_CMP, c6502_eu_pkg::FN_CPX, c6502_eu_pkg::FN_CPY: begin
            nxt.status[c6502_eu_pkg::FLAG_C] = ~diff[8];
            nxt.status = with_nz(nxt.status, diff[7:0]);
         end
         c6502_eu_pkg::FN_DEC: begin
            res.store_enable = 1'b1;
            res.store_data   = m - 8'd1;
            nxt.status = with_nz(cur.status, m - 8'd1);
         end
         c6502_eu_pkg::FN_INC: begin
            res.store_enable = 1'b1;
            res.store_data   = m + 8'd1;
            nxt.status = with_nz(cur.status, m + 8'd1);
         end
         c6502_eu_pkg::FN_DEX: begin
            nxt.x = cur.x - 8'd1;
            nxt.status = with_nz(cur.status, cur.x - 8'd1);
         end
         c6502_eu_pkg::FN_DEY: begin
            nxt.y = cur.y - 8'd1;
            nxt.status = with_nz(cur.status, cur.y - 8'd1);
         end
         c6502_eu_pkg::FN_INX: begin
            nxt.x = cur.x + 8'd1;
            nxt.status = with_nz(cur.status, cur.x + 8'd1);
         end
         c6502_eu_pkg::FN_INY: begin
            nxt.y = cur.y + 8'd1;
            nxt.status = with_nz(cur.status, cur.y + 8'd1);
         end
         c6502_eu_pkg::FN_LDA: begin
            nxt.acc = m;
            nxt.status = with_nz(cur.status, m);
         end
         c6502_eu_pkg::FN_LDX: begin
            nxt.x = m;
            nxt.status = with_nz(cur.status, m);
         end
         c6502_eu_pkg::FN_LDY: begin
            nxt.y = m;
            nxt.status = with_nz(cur.status, m);
         end
         c6502_eu_pkg::FN_NOP: ;
         c6502_eu_pkg::FN_STA: begin
            res.store_enable = 1'b1;
            res.store_data   = cur.acc;
         end
         c6502_eu_pkg::FN_STX: begin
            res.store_enable = 1'b1;
            res.store_data   = cur.x;
         end
         c6502_eu_pkg::FN_STY: begin
            res.store_enable = 1'b1;
            res.store_data   = cur.y;
         end
         c6502_eu_pkg::FN_TAX: begin
            nxt.x = cur.acc;
            nxt.status = with_nz(cur.status, cur.acc);
         end
         c6502_eu_pkg::FN_TAY: begin
            nxt.y = cur.acc;
            nxt.status = with_nz(cur.status, cur.acc);
         end
         c6502_eu_pkg::FN_TSX: begin
            nxt.x = cur.sp;
            nxt.status = with_nz(cur.status, cur.sp);
         end
         c6502_eu_pkg::FN_TXA: begin
            nxt.acc = cur.x;
            nxt.status = with_nz(cur.status, cur.x);
         end
         c6502_eu_pkg::FN_TXS: nxt.sp = cur.x;
         c6502_eu_pkg::FN_TYA: begin
            nxt.acc = cur.y;
            nxt.status = with_nz(cur.status, cur.y);
         end
         default: res.unsupported = 1'b1;
      endcase

      // Shifts and rotates go either to the accumulator or back to memory.
      if (shift_op) begin
         nxt.status[c6502_eu_pkg::FLAG_C] = shift_c;
         nxt.status = with_nz(nxt.status, shift_r);
         if (item.to_accumulator) begin
            nxt.acc = shift_r;
         end else begin
            res.store_enable = 1'b1;
            res.store_data   = shift_r;
         end
      end

      // Taken branch: program counter plus the sign-extended offset.
      if (is_branch && cond) begin
         res.branch_taken = 1'b1;
         res.next_pc      = target;
      end

      res.acc_value    = nxt.acc;
      res.x_value      = nxt.x;
      res.y_value      = nxt.y;
      res.sp_value     = nxt.sp;
      res.status_value = nxt.status;
   end

endmodule

// ----- rtl/cpu6502_execute_unit_core.sv -----
// An accepted request item is held in the input register, its response item in the
// response register. Throughput: one item per cycle while responses are taken; the
// register file is read and written in the execute stage, so each item sees the flags
// and registers left by the one before. Reset: synchronous, active high; A, X and Y
// clear, SP becomes 0xFD, status 0x24, and both pipeline stages empty.
module cpu6502_execute_unit_core (
   input logic                  clock,
   input logic                  reset,
   c6502_eu_req_if.sink         req_ch,
   c6502_eu_rsp_if.source       rsp_ch
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   c6502_eu_pkg::item_type   in_item_ff;
   c6502_eu_pkg::item_type   in_item_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   c6502_eu_pkg::result_type rsp_ff;
   c6502_eu_pkg::result_type rsp_in;
   c6502_eu_pkg::regs_type   state_ff;
   c6502_eu_pkg::regs_type   state_in;
   c6502_eu_pkg::regs_type   alu_nxt;
   c6502_eu_pkg::result_type alu_res;
   c6502_eu_pkg::item_type   req_item;
   logic                     exec_go;
   logic                     req_take;

   // The held item executes once the response register is free or draining.
   assign exec_go  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || exec_go;

   assign req_item.func           = req_ch.func;
   assign req_item.operand        = req_ch.operand;
   assign req_item.to_accumulator = req_ch.to_accumulator;
   assign req_item.current_pc     = req_ch.current_pc;

   // Execute stage
   c6502_eu_alu u_alu (
      .item (in_item_ff),
      .cur  (state_ff),
      .nxt  (alu_nxt),
      .res  (alu_res)
   );

   // Next-state selection for the input, state and response registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      state_in     = state_ff;
      if (exec_go) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = alu_res;
         state_in     = alu_nxt;
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff.acc    <= 8'd0;
         state_ff.x      <= 8'd0;
         state_ff.y      <= 8'd0;
         state_ff.sp     <= c6502_eu_pkg::SP_RESET;
         state_ff.status <= c6502_eu_pkg::STATUS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   // Response channel
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.acc_value    = rsp_ff.acc_value;
   assign rsp_ch.x_value      = rsp_ff.x_value;
   assign rsp_ch.y_value      = rsp_ff.y_value;
   assign rsp_ch.sp_value     = rsp_ff.sp_value;
   assign rsp_ch.status_value = rsp_ff.status_value;
   assign rsp_ch.store_enable = rsp_ff.store_enable;
   assign rsp_ch.store_data   = rsp_ff.store_data;
   assign rsp_ch.branch_taken = rsp_ff.branch_taken;
   assign rsp_ch.next_pc      = rsp_ff.next_pc;
   assign rsp_ch.unsupported  = rsp_ff.unsupported;

endmodule

// ----- tb/sv/exec_unit_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the execute unit, predicts each response item
// from the accepted request items and compares the two field by field.
module exec_unit_checker (
   input  logic    clock,
   input  logic    reset,
   c6502_eu_req_if req_mon,
   c6502_eu_rsp_if rsp_mon,
   output int      mismatch_count,
   output int      pending_count
);

   // Mirror of the programmer-visible registers, as the unit should hold them.
   c6502_eu_pkg::regs_type   arch_regs;
   c6502_eu_pkg::result_type due_results[$];

   // N and Z follow the value just produced.
   function automatic logic [7:0] nz_flags(logic [7:0] st, logic [7:0] v);
      st[c6502_eu_pkg::FLAG_Z] = (v == 8'h00);
      st[c6502_eu_pkg::FLAG_N] = v[7];
      return st;
   endfunction

   // Carries out one operation on the mirrored registers and returns the
   // response item that the unit must give for it.
   function automatic c6502_eu_pkg::result_type execute_op(c6502_eu_pkg::item_type op);
      c6502_eu_pkg::regs_type   r;
      c6502_eu_pkg::result_type res;
      logic [7:0] m;
      logic [7:0] src;
      logic [7:0] addend;
      logic [7:0] val;
      logic [7:0] cmp_reg;
      logic [8:0] sum;
      logic       cin;
      logic       is_branch;
      logic       cond;
      logic       writes_back;

      r           = arch_regs;
      res         = '0;
      m           = op.operand;
      src         = op.to_accumulator ? r.acc : m;
      cin         = r.status[c6502_eu_pkg::FLAG_C];
      is_branch   = 1'b0;
      cond        = 1'b0;
      writes_back = 1'b0;
      val         = 8'h00;
      cmp_reg     = 8'h00;

      case (op.func)
         c6502_eu_pkg::FN_ADC, c6502_eu_pkg::FN_SBC: begin
            // Subtraction adds the inverted operand, so borrow is the inverted carry.
            addend = (op.func == c6502_eu_pkg::FN_SBC) ? ~m : m;
            sum = {1'b0, r.acc} + {1'b0, addend} + {8'h00, cin};
            r.status[c6502_eu_pkg::FLAG_C] = sum[8];
            r.status[c6502_eu_pkg::FLAG_V] = (~(r.acc[7] ^ addend[7])) & (r.acc[7] ^ sum[7]);
            r.acc = sum[7:0];
            r.status = nz_flags(r.status, r.acc);
         end
         c6502_eu_pkg::FN_AND: begin
            r.acc = r.acc & m;
            r.status = nz_flags(r.status, r.acc);
         end
         c6502_eu_pkg::FN_EOR: begin
            r.acc = r.acc ^ m;
            r.status = nz_flags(r.status, r.acc);
         end
         c6502_eu_pkg::FN_ORA: begin
            r.acc = r.acc | m;
            r.status = nz_flags(r.status, r.acc);
         end
         c6502_eu_pkg::FN_BIT: begin
            r.status[c6502_eu_pkg::FLAG_Z] = ((m & r.acc) == 8'h00);
            r.status[c6502_eu_pkg::FLAG_V] = m[6];
            r.status[c6502_eu_pkg::FLAG_N] = m[7];
         end
         c6502_eu_pkg::FN_ASL, c6502_eu_pkg::FN_LSR, c6502_eu_pkg::FN_ROL,
         c6502_eu_pkg::FN_ROR: begin
            // Shifts and rotates work on A or on the operand, which goes back to memory.
            case (op.func)
               c6502_eu_pkg::FN_ASL: begin
                  r.status[c6502_eu_pkg::FLAG_C] = src[7];
                  val = {src[6:0], 1'b0};
               end
               c6502_eu_pkg::FN_LSR: begin
                  r.status[c6502_eu_pkg::FLAG_C] = src[0];
                  val = {1'b0, src[7:1]};
               end
               c6502_eu_pkg::FN_ROL: begin
                  r.status[c6502_eu_pkg::FLAG_C] = src[7];
                  val = {src[6:0], cin};
               end
               default: begin
                  r.status[c6502_eu_pkg::FLAG_C] = src[0];
                  val = {cin, src[7:1]};
               end
            endcase
            r.status = nz_flags(r.status, val);
            if (op.to_accumulator) begin
               r.acc = val;
            end else begin
               writes_back = 1'b1;
            end
         end
         c6502_eu_pkg::FN_BCC: begin
            is_branch = 1'b1;
            cond = !r.status[c6502_eu_pkg::FLAG_C];
         end
         c6502_eu_pkg::FN_BCS: begin
            is_branch = 1'b1;
            cond = r.status[c6502_eu_pkg::FLAG_C];
         end
         c6502_eu_pkg::FN_BEQ: begin
            is_branch = 1'b1;
            cond = r.status[c6502_eu_pkg::FLAG_Z];
         end
         c6502_eu_pkg::FN_BNE: begin
            is_branch = 1'b1;
            cond = !r.status[c6502_eu_pkg::FLAG_Z];
         end
         c6502_eu_pkg::FN_BMI: begin
            is_branch = 1'b1;
            cond = r.status[c6502_eu_pkg::FLAG_N];
         end
         c6502_eu_pkg::FN_BPL: begin
            is_branch = 1'b1;
            cond = !r.status[c6502_eu_pkg::FLAG_N];
         end
         c6502_eu_pkg::FN_BVC: begin
            is_branch = 1'b1;
            cond = !r.status[c6502_eu_pkg::FLAG_V];
         end
         c6502_eu_pkg::FN_BVS: begin
            is_branch = 1'b1;
            cond = r.status[c6502_eu_pkg::FLAG_V];
         end
         c6502_eu_pkg::FN_CLC: r.status[c6502_eu_pkg::FLAG_C] = 1'b0;
         c6502_eu_pkg::FN_CLD: r.status[c6502_eu_pkg::FLAG_D] = 1'b0;
         c6502_eu_pkg::FN_CLI: r.status[c6502_eu_pkg::FLAG_I] = 1'b0;
         c6502_eu_pkg::FN_CLV: r.status[c6502_eu_pkg::FLAG_V] = 1'b0;
         c6502_eu_pkg::FN_SEC: r.status[c6502_eu_pkg::FLAG_C] = 1'b1;
         c6502_eu_pkg::FN_SED: r.status[c6502_eu_pkg::FLAG_D] = 1'b1;
         c6502_eu_pkg::FN_SEI: r.status[c6502_eu_pkg::FLAG_I] = 1'b1;
         c6502_eu_pkg::FN_CMP, c6502_eu_pkg::FN_CPX, c6502_eu_pkg::FN_CPY: begin
            // Carry means the register is at least the operand.
            cmp_reg = (op.func == c6502_eu_pkg::FN_CMP) ? r.acc :
                      (op.func == c6502_eu_pkg::FN_CPX) ? r.x : r.y;
            r.status[c6502_eu_pkg::FLAG_C] = (cmp_reg >= m);
            r.status = nz_flags(r.status, cmp_reg - m);
         end
         c6502_eu_pkg::FN_DEC, c6502_eu_pkg::FN_INC: begin
            val = (op.func == c6502_eu_pkg::FN_DEC) ? m - 8'd1 : m + 8'd1;
            r.status = nz_flags(r.status, val);
            writes_back = 1'b1;
         end
         c6502_eu_pkg::FN_DEX: begin
            r.x = r.x - 8'd1;
            r.status = nz_flags(r.status, r.x);
         end
         c6502_eu_pkg::FN_DEY: begin
            r.y = r.y - 8'd1;
            r.status = nz_flags(r.status, r.y);
         end
         c6502_eu_pkg::FN_INX: begin
            r.x = r.x + 8'd1;
            r.status = nz_flags(r.status, r.x);
         end
         c6502_eu_pkg::FN_INY: begin
            r.y = r.y + 8'd1;
            r.status = nz_flags(r.status, r.y);
         end
         c6502_eu_pkg::FN_LDA: begin
            r.acc = m;
            r.status = nz_flags(r.status, m);
         end
         c6502_eu_pkg::FN_LDX: begin
            r.x = m;
            r.status = nz_flags(r.status, m);
         end
         c6502_eu_pkg::FN_LDY: begin
            r.y = m;
            r.status = nz_flags(r.status, m);
         end
         c6502_eu_pkg::FN_NOP: ;
         c6502_eu_pkg::FN_STA: begin
            writes_back = 1'b1;
            val = r.acc;
         end
         c6502_eu_pkg::FN_STX: begin
            writes_back = 1'b1;
            val = r.x;
         end
         c6502_eu_pkg::FN_STY: begin
            writes_back = 1'b1;
            val = r.y;
         end
         c6502_eu_pkg::FN_TAX: begin
            r.x = r.acc;
            r.status = nz_flags(r.status, r.x);
         end
         c6502_eu_pkg::FN_TAY: begin
            r.y = r.acc;
            r.status = nz_flags(r.status, r.y);
         end
         c6502_eu_pkg::FN_TSX: begin
            r.x = r.sp;
            r.status = nz_flags(r.status, r.x);
         end
         c6502_eu_pkg::FN_TXA: begin
            r.acc = r.x;
            r.status = nz_flags(r.status, r.acc);
         end
         c6502_eu_pkg::FN_TYA: begin
            r.acc = r.y;
            r.status = nz_flags(r.status, r.acc);
         end
         // The stack pointer transfer leaves the flags alone.
         c6502_eu_pkg::FN_TXS: r.sp = r.x;
         default: res.unsupported = 1'b1;
      endcase

      arch_regs = r;
      res.acc_value    = r.acc;
      res.x_value      = r.x;
      res.y_value      = r.y;
      res.sp_value     = r.sp;
      res.status_value = r.status;
      res.store_enable = writes_back;
      res.store_data   = writes_back ? val : 8'h00;
      res.branch_taken = is_branch && cond;
      res.next_pc      = (is_branch && cond) ? op.current_pc + {{8{m[7]}}, m}
                                             : op.current_pc;
      return res;
   endfunction

   // Every mismatch is counted and reported.
   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Responses are matched first: none may answer a request of the same edge.
   always @(posedge clock) begin
      c6502_eu_pkg::item_type   req_item;
      c6502_eu_pkg::result_type want;
      if (reset) begin
         arch_regs = '{acc: 8'h00, x: 8'h00, y: 8'h00,
                       sp: c6502_eu_pkg::SP_RESET, status: c6502_eu_pkg::STATUS_RESET};
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: response item with none expected, got acc %0h status %0h",
                        $time, rsp_mon.acc_value, rsp_mon.status_value);
            end else begin
               want = due_results.pop_front();
               check_field("acc_value", 16'(want.acc_value), 16'(rsp_mon.acc_value));
               check_field("x_value", 16'(want.x_value), 16'(rsp_mon.x_value));
               check_field("y_value", 16'(want.y_value), 16'(rsp_mon.y_value));
               check_field("sp_value", 16'(want.sp_value), 16'(rsp_mon.sp_value));
               check_field("status_value", 16'(want.status_value),
                           16'(rsp_mon.status_value));
               check_field("store_enable", 16'(want.store_enable),
                           16'(rsp_mon.store_enable));
               check_field("store_data", 16'(want.store_data), 16'(rsp_mon.store_data));
               check_field("branch_taken", 16'(want.branch_taken),
                           16'(rsp_mon.branch_taken));
               check_field("next_pc", want.next_pc, rsp_mon.next_pc);
               check_field("unsupported", 16'(want.unsupported),
                           16'(rsp_mon.unsupported));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_item.func           = req_mon.func;
            req_item.operand        = req_mon.operand;
            req_item.to_accumulator = req_mon.to_accumulator;
            req_item.current_pc     = req_mon.current_pc;
            due_results.push_back(execute_op(req_item));
         end
      end
      pending_count = due_results.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

// Drives operations into the execute unit with random gaps and stalls and
// gives the verdict from the checker's count.
module testbench;

   localparam int RANDOM_OPS = 1800;
   localparam int PHASES     = 8;

   // Range of operation codes that the unit does not support
   localparam logic [5:0] FN_UNSUP_FIRST = 6'd47;
   localparam logic [5:0] FN_UNSUP_LAST  = 6'd63;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   mismatch_count;
   int   pending_count;

   c6502_eu_req_if req_ch ();
   c6502_eu_rsp_if rsp_ch ();

   cpu6502_execute_unit_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   exec_unit_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hands one operation to the unit after a random gap and holds it until taken.
   task automatic send_op(logic [5:0] func, logic [7:0] operand, logic acc_mode,
                          logic [15:0] pc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.func           <= func;
      req_ch.operand        <= operand;
      req_ch.to_accumulator <= acc_mode;
      req_ch.current_pc     <= pc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Operand bytes lean towards the sign and carry boundaries, so that
   // compares often meet equal values.
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[7];
      corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
      if ($urandom_range(99) < 40) begin
         return corners[$urandom_range(6)];
      end
      return 8'($urandom_range(255));
   endfunction

   // The receiver stalls at random on every edge.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      logic [5:0]  func;
      logic [15:0] pc;
      req_ch.valid          <= 1'b0;
      req_ch.func           <= c6502_eu_pkg::FN_NOP;
      req_ch.operand        <= 8'h00;
      req_ch.to_accumulator <= 1'b0;
      req_ch.current_pc     <= 16'h0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: overflow and carry at the sign boundary, branches that
      // wrap the program counter both ways, compares on equal and below,
      // BIT, the flag-free stack transfer, shifts on both targets and
      // unsupported codes.
      send_op(c6502_eu_pkg::FN_LDA, 8'h7F, 1'b0, 16'h0000);
      send_op(c6502_eu_pkg::FN_ADC, 8'h01, 1'b0, 16'h0001);
      send_op(c6502_eu_pkg::FN_BVS, 8'h80, 1'b0, 16'h0000);
      send_op(c6502_eu_pkg::FN_BMI, 8'h7F, 1'b0, 16'hFFFF);
      send_op(c6502_eu_pkg::FN_SBC, 8'h01, 1'b0, 16'h1234);
      send_op(c6502_eu_pkg::FN_CMP, 8'h7E, 1'b0, 16'h1235);
      send_op(c6502_eu_pkg::FN_BEQ, 8'hFE, 1'b0, 16'h8000);
      send_op(c6502_eu_pkg::FN_CMP, 8'hFF, 1'b1, 16'h8001);
      send_op(c6502_eu_pkg::FN_BCC, 8'h10, 1'b1, 16'h8002);
      send_op(c6502_eu_pkg::FN_CPX, 8'h00, 1'b0, 16'h8003);
      send_op(c6502_eu_pkg::FN_BIT, 8'hC0, 1'b0, 16'h8004);
      send_op(c6502_eu_pkg::FN_LDX, 8'hFF, 1'b0, 16'h8005);
      send_op(c6502_eu_pkg::FN_TXS, 8'h00, 1'b0, 16'h8006);
      send_op(c6502_eu_pkg::FN_CLV, 8'h00, 1'b0, 16'h8007);
      send_op(c6502_eu_pkg::FN_TSX, 8'h00, 1'b0, 16'h8008);
      send_op(c6502_eu_pkg::FN_SEC, 8'h00, 1'b0, 16'h8009);
      send_op(c6502_eu_pkg::FN_ROL, 8'h00, 1'b1, 16'h800A);
      send_op(c6502_eu_pkg::FN_ROR, 8'h01, 1'b0, 16'h800B);
      send_op(c6502_eu_pkg::FN_ASL, 8'h80, 1'b0, 16'h800C);
      send_op(c6502_eu_pkg::FN_LSR, 8'hFF, 1'b1, 16'h800D);
      send_op(c6502_eu_pkg::FN_DEC, 8'h00, 1'b0, 16'h800E);
      send_op(c6502_eu_pkg::FN_INC, 8'hFF, 1'b0, 16'h800F);
      send_op(FN_UNSUP_FIRST, 8'hFF, 1'b1, 16'hFFFF);
      send_op(FN_UNSUP_LAST, 8'h00, 1'b0, 16'h0000);
      send_op(c6502_eu_pkg::FN_STY, 8'h00, 1'b0, 16'h0100);

      // Random part in phases of idling: none, sender, receiver, both.
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 72;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 72;
            end
            default: begin
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase
         repeat (RANDOM_OPS / PHASES) begin
            if ($urandom_range(99) < 5) begin
               func = 6'($urandom_range(FN_UNSUP_LAST, FN_UNSUP_FIRST));
            end else begin
               func = 6'($urandom_range(c6502_eu_pkg::FN_TYA, c6502_eu_pkg::FN_ADC));
            end
            if ($urandom_range(99) < 10) begin
               pc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end else begin
               pc = 16'($urandom_range(65535));
            end
            send_op(func, pick_byte(), 1'($urandom_range(1)), pc);
         end
      end

      // Let every response come back, then allow for the pipeline.
      req_ch.valid <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guard against a unit that hangs.
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
